### sv/fccd_pkg.sv
// Package for the frame CRC checker / deframer.
// Holds the frame constants, the summary record type and the byte-wide CRC-16 update.
// No dependencies.
`default_nettype none

package fccd_pkg;

  localparam int unsigned HdrLen     = 7;
  localparam int unsigned CntW       = 9;
  localparam int unsigned OutDataW   = 88;

  localparam logic [15:0]     CrcInit  = 16'hFFFF;
  localparam logic [15:0]     CrcPoly  = 16'h1021;
  localparam logic [CntW-1:0] MinFrame = 9'd9;
  localparam logic [CntW-1:0] CountMax = 9'd511;

  // frame summary, one per frame
  typedef struct packed {
    logic        crc_ok;
    logic        too_short;
    logic [4:0]  msg_kind;
    logic        confirmed_flag;
    logic [1:0]  proto_version;
    logic [15:0] target_addr;
    logic [15:0] source_addr;
    logic [7:0]  frame_count;
    logic [7:0]  declared_payload_len;
    logic [8:0]  received_bytes;
    logic [15:0] received_crc;
  } summary_t;

  // CRC-16/CCITT-FALSE, one byte, MSB first
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ((c << 1) ^ CrcPoly) : (c << 1);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

### sv/fccd_frame_track.sv
// Per-frame tracking: byte count, header capture, two-byte tail delay, running CRC.
// Builds the summary record on the final byte. Depends on fccd_pkg.
`default_nettype none

module fccd_frame_track import fccd_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       accept_i,
  input  wire logic [7:0] byte_i,
  input  wire logic       last_i,
  output summary_t        summary_o,
  output logic            summary_valid_o
);

  logic [15:0]     crc_q, crc_d;
  logic [7:0]      tail0_q, tail1_q;
  logic [CntW-1:0] count_q, count_d;
  logic [7:0]      hdr_q [HdrLen];
  logic [7:0]      hdr_d [HdrLen];
  logic [15:0]     rx_crc;
  logic            short_frame;

  always_comb begin
    crc_d   = (count_q >= CntW'(2)) ? crc16_byte(crc_q, tail1_q) : crc_q;
    count_d = (count_q < CountMax) ? count_q + CntW'(1) : CountMax;
    for (int i = 0; i < HdrLen; i++) begin
      hdr_d[i] = (count_q == CntW'(i)) ? byte_i : hdr_q[i];
    end
  end

  assign rx_crc      = {byte_i, tail0_q};
  assign short_frame = count_d < MinFrame;

  always_comb begin
    summary_o.crc_ok               = !short_frame && (crc_d == rx_crc);
    summary_o.too_short            = short_frame;
    summary_o.msg_kind             = hdr_d[0][4:0];
    summary_o.confirmed_flag       = hdr_d[0][5];
    summary_o.proto_version        = hdr_d[0][7:6];
    summary_o.target_addr          = {hdr_d[2], hdr_d[1]};
    summary_o.source_addr          = {hdr_d[4], hdr_d[3]};
    summary_o.frame_count          = hdr_d[5];
    summary_o.declared_payload_len = hdr_d[6];
    summary_o.received_bytes       = count_d;
    summary_o.received_crc         = rx_crc;
  end

  assign summary_valid_o = accept_i && last_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q   <= CrcInit;
      tail0_q <= '0;
      tail1_q <= '0;
      count_q <= '0;
      for (int i = 0; i < HdrLen; i++) hdr_q[i] <= '0;
    end else if (accept_i) begin
      if (last_i) begin
        crc_q   <= CrcInit;
        tail0_q <= '0;
        tail1_q <= '0;
        count_q <= '0;
        for (int i = 0; i < HdrLen; i++) hdr_q[i] <= '0;
      end else begin
        crc_q   <= crc_d;
        tail0_q <= byte_i;
        tail1_q <= tail0_q;
        count_q <= count_d;
        for (int i = 0; i < HdrLen; i++) hdr_q[i] <= hdr_d[i];
      end
    end
  end

`ifndef ASSERT_OFF
  a_clear_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && last_i |=> count_q == '0 && crc_q == CrcInit)
    else $error("frame state not cleared after final byte");
  a_count_steps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && !last_i && count_q < CountMax |=> count_q == $past(count_q) + CntW'(1))
    else $error("byte count did not advance");
  a_short_no_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    summary_valid_o |-> !(summary_o.crc_ok && summary_o.too_short))
    else $error("short frame flagged as CRC ok");
`endif

endmodule

`default_nettype wire

### sv/fccd_out_reg.sv
// Result register for the summary stream; the input side stalls only while a
// result waits on a stalled output. Depends on fccd_pkg.
`default_nettype none

module fccd_out_reg import fccd_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     load_i,
  input  wire summary_t summary_i,
  output logic          ready_o,
  input  wire logic     m_ready_i,
  output logic          m_valid_o,
  output summary_t      m_summary_o
);

  logic     valid_q;
  summary_t data_q;

  assign ready_o     = !valid_q || m_ready_i;
  assign m_valid_o   = valid_q;
  assign m_summary_o = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= load_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && load_i) begin
      data_q <= summary_i;
    end
  end

`ifndef ASSERT_OFF
  a_load_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ready_o && load_i |=> valid_q)
    else $error("loaded summary not presented");
  a_hold_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && !m_ready_i |=> valid_q && $stable(data_q))
    else $error("stalled summary lost or changed");
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && !m_ready_i |-> !ready_o)
    else $error("result register open while full and stalled");
`endif

endmodule

`default_nettype wire

### sv/frame_crc_checker_deframer.sv
// Top level of the frame CRC checker / deframer (CRC-16/CCITT-FALSE).
// Instantiates fccd_frame_track and fccd_out_reg; depends on fccd_pkg.
//
//   channel  dir  tdata                         tlast       width
//   s_axis   in   [7:0] data_byte               last_byte   8
//   m_axis   out  frame summary, see port note  -           88
//
// One byte per cycle unless a summary waits on a stalled m_axis; the byte-wide CRC
// update and compare are combinational between the frame state and the result register.
// The summary appears in the cycle after the final byte is accepted.
// A stalled m_axis holds the summary; while it waits, s_axis_tready is low and
// no byte is accepted until the summary transaction completes.
// Reset clears the frame state and drops any pending summary.
`default_nettype none

module frame_crc_checker_deframer import fccd_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  input  wire logic [7:0]          s_axis_tdata,  // [7:0] data_byte
  input  wire logic                s_axis_tlast,  // last_byte
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  // [0] crc_ok, [1] too_short, [6:2] message type, [7] confirmed_flag,
  // [9:8] proto_version, [25:10] target_addr, [41:26] source_addr,
  // [49:42] frame_count, [57:50] declared_payload_len, [66:58] received_bytes,
  // [82:67] received_crc, [87:83] zero
  output logic [OutDataW-1:0]      m_axis_tdata
);

  logic     accept;
  logic     out_ready;
  logic     sum_valid;
  summary_t sum_new, sum_out;

  assign s_axis_tready = out_ready;
  assign accept        = s_axis_tvalid && out_ready;

  fccd_frame_track u_track (
    .clk_i,
    .rst_ni,
    .accept_i        (accept),
    .byte_i          (s_axis_tdata),
    .last_i          (s_axis_tlast),
    .summary_o       (sum_new),
    .summary_valid_o (sum_valid)
  );

  fccd_out_reg u_out (
    .clk_i,
    .rst_ni,
    .load_i      (sum_valid),
    .summary_i   (sum_new),
    .ready_o     (out_ready),
    .m_ready_i   (m_axis_tready),
    .m_valid_o   (m_axis_tvalid),
    .m_summary_o (sum_out)
  );

  assign m_axis_tdata = {5'b0,
                         sum_out.received_crc,
                         sum_out.received_bytes,
                         sum_out.declared_payload_len,
                         sum_out.frame_count,
                         sum_out.source_addr,
                         sum_out.target_addr,
                         sum_out.proto_version,
                         sum_out.confirmed_flag,
                         sum_out.msg_kind,
                         sum_out.too_short,
                         sum_out.crc_ok};

`ifndef ASSERT_OFF
  a_last_gives_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tlast |=> m_axis_tvalid)
    else $error("final byte produced no summary");
  a_short_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[1] == (m_axis_tdata[66:58] < MinFrame))
    else $error("too_short disagrees with byte count");
  a_nonzero_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[66:58] != '0 && m_axis_tdata[87:83] == '0)
    else $error("summary with zero byte count or stray pad bits");
`endif

endmodule

`default_nettype wire

### tb/frame_crc_checker_deframer_tb.sv
// Self-checking testbench for frame_crc_checker_deframer: byte frames in, summaries out.
// Directed table, then random frames: valid and corrupted CRC tails, short, no CRC, long.
// Depends on fccd_pkg and the frame_crc_checker_deframer RTL.
`default_nettype none

module frame_crc_checker_deframer_tb;
  import fccd_pkg::*;

  typedef enum logic [1:0] {KnownNone, KnownOnesByte, KnownZeroByte, KnownCheckFrame} known_e;
  typedef enum logic [1:0] {RxOpen, RxHalf, RxMostly, RxChoked} rx_mode_e;

  typedef struct packed {
    logic        crc_ok;
    logic        too_short;
    logic [4:0]  msg_kind;
    logic        confirmed;
    logic [1:0]  version;
    logic [15:0] target;
    logic [15:0] source;
    logic [7:0]  frame_cnt;
    logic [7:0]  payload_len;
    logic [8:0]  rx_bytes;
    logic [15:0] rx_crc;
  } frame_sum_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    known_e     known;
  } byte_item_t;

  localparam int unsigned NumDirected = 24;
  localparam int unsigned NumRandom   = 1800;
  localparam int unsigned HoldStart   = 600;
  localparam int unsigned HoldLen     = 400;

  localparam byte_item_t DirTable [NumDirected] = '{
    '{8'hFF, 1'b1, KnownOnesByte},
    '{8'h00, 1'b1, KnownZeroByte},
    '{8'h5A, 1'b0, KnownNone}, '{8'hA5, 1'b1, KnownNone},
    // "123456789" followed by its CRC, low byte first
    '{8'h31, 1'b0, KnownNone}, '{8'h32, 1'b0, KnownNone}, '{8'h33, 1'b0, KnownNone},
    '{8'h34, 1'b0, KnownNone}, '{8'h35, 1'b0, KnownNone}, '{8'h36, 1'b0, KnownNone},
    '{8'h37, 1'b0, KnownNone}, '{8'h38, 1'b0, KnownNone}, '{8'h39, 1'b0, KnownNone},
    '{8'hB1, 1'b0, KnownNone}, '{8'h29, 1'b1, KnownCheckFrame},
    // minimum length, bad CRC
    '{8'hFF, 1'b0, KnownNone}, '{8'hFF, 1'b0, KnownNone}, '{8'hFF, 1'b0, KnownNone},
    '{8'hFF, 1'b0, KnownNone}, '{8'hFF, 1'b0, KnownNone}, '{8'hFF, 1'b0, KnownNone},
    '{8'hFF, 1'b0, KnownNone}, '{8'hFF, 1'b0, KnownNone}, '{8'hFF, 1'b1, KnownNone}
  };

  logic                clk_i;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [7:0]          s_axis_tdata;
  logic                s_axis_tlast;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [OutDataW-1:0] m_axis_tdata;

  byte_item_t  stim [$];
  frame_sum_t  expected_sums [$];
  int unsigned acc_idx = 0;
  int unsigned errors = 0;

  // frame predictor state
  logic [15:0] crc_run;
  logic [7:0]  tail_new;
  logic [7:0]  tail_old;
  logic [8:0]  byte_cnt;
  logic [7:0]  hdr [HdrLen];

  frame_crc_checker_deframer i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #2000000;
    $display("tb: failure");
    $finish;
  end

  function automatic logic [15:0] crc_ccitt_step(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    logic        fb;
    c = crc;
    for (int i = 7; i >= 0; i--) begin
      fb = c[15] ^ b[i];
      c  = {c[14:0], 1'b0} ^ (fb ? CrcPoly : 16'h0000);
    end
    return c;
  endfunction

  function automatic frame_sum_t known_sum(input known_e k);
    case (k)
      KnownOnesByte:   return '{1'b0, 1'b1, 5'h1F, 1'b1, 2'd3, 16'h0, 16'h0, 8'h0, 8'h0,
                                9'd1, 16'hFF00};
      KnownCheckFrame: return '{1'b1, 1'b0, 5'h11, 1'b1, 2'd0, 16'h3332, 16'h3534, 8'h36,
                                8'h37, 9'd11, 16'h29B1};
      default:         return '{1'b0, 1'b1, 5'h00, 1'b0, 2'd0, 16'h0, 16'h0, 8'h0, 8'h0,
                                9'd1, 16'h0000};
    endcase
  endfunction

  task automatic clear_frame_state();
    crc_run  = CrcInit;
    tail_new = '0;
    tail_old = '0;
    byte_cnt = '0;
    foreach (hdr[i]) hdr[i] = '0;
  endtask

  task automatic deframe_byte(input logic [7:0] b, input logic last, output bit done,
                              output frame_sum_t s);
    logic [8:0]  cnt;
    logic [15:0] rx;
    if (byte_cnt >= 9'd2) crc_run = crc_ccitt_step(crc_run, tail_old);
    tail_old = tail_new;
    tail_new = b;
    if (byte_cnt < HdrLen) hdr[byte_cnt] = b;
    cnt      = (byte_cnt < CountMax) ? byte_cnt + 9'd1 : CountMax;
    byte_cnt = cnt;
    done     = last;
    s        = '0;
    if (last) begin
      rx            = {tail_new, tail_old};
      s.too_short   = cnt < MinFrame;
      s.crc_ok      = !s.too_short && (crc_run == rx);
      s.msg_kind    = hdr[0][4:0];
      s.confirmed   = hdr[0][5];
      s.version     = hdr[0][7:6];
      s.target      = {hdr[2], hdr[1]};
      s.source      = {hdr[4], hdr[3]};
      s.frame_cnt   = hdr[5];
      s.payload_len = hdr[6];
      s.rx_bytes    = cnt;
      s.rx_crc      = rx;
      clear_frame_state();
    end
  endtask

  function automatic frame_sum_t unpack_summary(input logic [OutDataW-1:0] d);
    frame_sum_t s;
    s.crc_ok      = d[0];
    s.too_short   = d[1];
    s.msg_kind    = d[6:2];
    s.confirmed   = d[7];
    s.version     = d[9:8];
    s.target      = d[25:10];
    s.source      = d[41:26];
    s.frame_cnt   = d[49:42];
    s.payload_len = d[57:50];
    s.rx_bytes    = d[66:58];
    s.rx_crc      = d[82:67];
    return s;
  endfunction

  task automatic report(input string msg);
    $display("ERROR @%0t: %s", $time, msg);
    errors++;
  endtask

  task automatic check_field(input string name, input logic [15:0] got, input logic [15:0] want);
    if (got !== want) report($sformatf("%s got %h want %h", name, got, want));
  endtask

  task automatic compare_summary(input frame_sum_t got, input frame_sum_t want);
    check_field("crc_ok", 16'(got.crc_ok), 16'(want.crc_ok));
    check_field("too_short", 16'(got.too_short), 16'(want.too_short));
    check_field("msg_kind", 16'(got.msg_kind), 16'(want.msg_kind));
    check_field("confirmed_flag", 16'(got.confirmed), 16'(want.confirmed));
    check_field("proto_version", 16'(got.version), 16'(want.version));
    check_field("target_addr", got.target, want.target);
    check_field("source_addr", got.source, want.source);
    check_field("frame_count", 16'(got.frame_cnt), 16'(want.frame_cnt));
    check_field("declared_payload_len", 16'(got.payload_len), 16'(want.payload_len));
    check_field("received_bytes", 16'(got.rx_bytes), 16'(want.rx_bytes));
    check_field("received_crc", got.rx_crc, want.rx_crc);
  endtask

  task automatic add_frame(input int unsigned len, input bit with_crc, input bit corrupt);
    logic [7:0]  frame_bytes [$];
    logic [15:0] crc;
    int unsigned pos;
    crc = CrcInit;
    for (int unsigned i = 0; i < len; i++) frame_bytes.push_back(8'($urandom));
    if (with_crc) begin
      for (int unsigned i = 0; i < len - 2; i++) crc = crc_ccitt_step(crc, frame_bytes[i]);
      frame_bytes[len-2] = crc[7:0];
      frame_bytes[len-1] = crc[15:8];
    end
    if (corrupt) begin
      pos = $urandom_range(0, len - 1);
      frame_bytes[pos] ^= 8'(1 << $urandom_range(0, 7));
    end
    foreach (frame_bytes[i])
      stim.push_back(byte_item_t'{frame_bytes[i], i == len - 1, KnownNone});
  endtask

  // input side: predict on every accepted byte
  always @(posedge clk_i) begin : in_mon
    bit         done;
    frame_sum_t s;
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      deframe_byte(s_axis_tdata, s_axis_tlast, done, s);
      if (done)
        expected_sums.push_back(stim[acc_idx].known == KnownNone ? s
                                                                  : known_sum(stim[acc_idx].known));
      acc_idx++;
    end
  end

  // output side: compare each summary transaction with the oldest expectation
  always @(posedge clk_i) begin : out_mon
    frame_sum_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_sums.size() == 0) begin
        report($sformatf("unexpected summary %h", m_axis_tdata));
      end else begin
        want = expected_sums.pop_front();
        compare_summary(unpack_summary(m_axis_tdata), want);
      end
    end
  end

  // receiver stall pattern, with one long hold-off
  initial begin
    int unsigned rx_cycle;
    int unsigned mode_left;
    rx_mode_e    mode;
    m_axis_tready = 1'b0;
    rx_cycle      = 0;
    mode_left     = 0;
    mode          = RxOpen;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      rx_cycle++;
      if (rx_cycle == HoldStart) begin
        m_axis_tready = 1'b0;
        repeat (HoldLen) @(negedge clk_i);
      end
      if (mode_left == 0) begin
        mode      = rx_mode_e'($urandom_range(0, 3));
        mode_left = $urandom_range(20, 150);
      end
      mode_left--;
      case (mode)
        RxOpen:   m_axis_tready = 1'b1;
        RxHalf:   m_axis_tready = 1'($urandom_range(0, 1));
        RxMostly: m_axis_tready = ($urandom_range(0, 3) != 0);
        default:  m_axis_tready = ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  // sender: build stimulus, reset, then drive in bursts
  initial begin
    int unsigned burst_left;
    int unsigned gap;
    int unsigned pick;
    int unsigned nfr;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;
    rst_ni        = 1'b0;
    clear_frame_state();

    foreach (DirTable[i]) stim.push_back(DirTable[i]);
    nfr = 0;
    while (stim.size() < NumDirected + NumRandom) begin
      pick = $urandom_range(0, 99);
      if (nfr == 10 || nfr == 30) add_frame($urandom_range(512, 540), 1'b1, 1'b0);
      else if (pick < 65)         add_frame($urandom_range(9, 40), 1'b1, 1'b0);
      else if (pick < 78)         add_frame($urandom_range(9, 40), 1'b1, 1'b1);
      else if (pick < 92)         add_frame($urandom_range(1, 8), 1'b0, 1'b0);
      else                        add_frame($urandom_range(9, 60), 1'b0, 1'b0);
      nfr++;
    end

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    burst_left = 0;
    for (int unsigned idx = 0; idx < stim.size(); idx++) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 48);
        gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        if (gap != 0) begin
          s_axis_tvalid = 1'b0;
          repeat (gap) @(negedge clk_i);
        end
      end
      s_axis_tvalid = 1'b1;
      s_axis_tdata  = stim[idx].data;
      s_axis_tlast  = stim[idx].last;
      do @(posedge clk_i); while (!s_axis_tready);
      burst_left--;
      @(negedge clk_i);
    end
    s_axis_tvalid = 1'b0;

    while (expected_sums.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
    if (errors == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule

`default_nettype wire

### filelist.f
sv/fccd_pkg.sv
sv/fccd_frame_track.sv
sv/fccd_out_reg.sv
sv/frame_crc_checker_deframer.sv
tb/frame_crc_checker_deframer_tb.sv
